// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the converter RTL; each uses the enclosing clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/cdn_pkg.sv =====
// Shared types and field widths of the calendar day-number converter.
package cdn_pkg;

    // Field widths of the input and result items.
    localparam int JDN_W   = 22;
    localparam int YEAR_W  = 12;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;

    // Source calendar selected by the opcode field.
    typedef enum logic
    {
        CAL_GREG = 1'b0,
        CAL_ETH  = 1'b1
    } cal_t;

    // One queue entry: the day number and the range-error flag of the date.
    typedef struct packed
    {
        logic             err;
        logic [JDN_W-1:0] jdn;
    } cdn_entry_t;

endpackage

// ===== hdl/cdn_fifo.sv =====
// Small queue of day numbers between the front and back pipelines.
`include "assert_macros.svh"

module cdn_fifo import cdn_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_valid,
    output logic       wr_ready,
    input  cdn_entry_t wr_data,
    output logic       rd_valid,
    input  logic       rd_ready,
    output cdn_entry_t rd_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    cdn_entry_t      mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            push;
    logic            pop;

    // Handshake status comes straight from the fill count.
    assign wr_ready = (count_reg != FULL_CNT);
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // Pointer and count update for each transfer on either side.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    `ASSERT_ALWAYS(a_count_bound, count_reg <= FULL_CNT, "queue count above depth")
    `ASSERT_NEXT(a_count_inc, push && !pop, count_reg == $past(count_reg) + CW'(1), "push lost")
    `ASSERT_NEXT(a_count_dec, pop && !push, count_reg == $past(count_reg) - CW'(1), "pop lost")

endmodule

// ===== hdl/cdn_front.sv =====
// Front pipeline: checks the input date and forms its Julian day number.
module cdn_front import cdn_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               opcode,
    input  logic [YEAR_W-1:0]  year_in,
    input  logic [MONTH_W-1:0] month_in,
    input  logic [DAY_W-1:0]   day_in,
    output logic               q_valid,
    input  logic               q_ready,
    output cdn_entry_t         q_data
);

    localparam logic [YEAR_W-1:0]  YEAR_MIN    = 12'd1000;
    localparam logic [YEAR_W-1:0]  YEAR_MAX    = 12'd3000;
    localparam logic [MONTH_W-1:0] GREG_MONTHS = 4'd12;
    localparam logic [MONTH_W-1:0] ETH_MONTHS  = 4'd13;
    localparam logic [MONTH_W-1:0] FEBRUARY    = 4'd2;
    localparam logic [JDN_W-1:0]   ETH_EPOCH   = 22'd1724220;
    localparam logic [JDN_W-1:0]   GREG_OFFSET = 22'd32075;

    // Days contributed by the month in the Gregorian formula, (367*(m-2-12a))/12.
    function automatic logic [8:0] month_term(input logic [MONTH_W-1:0] m);
        logic [8:0] v;
        unique case (m)
            4'd1:    v = 9'd336;
            4'd2:    v = 9'd367;
            4'd3:    v = 9'd30;
            4'd4:    v = 9'd61;
            4'd5:    v = 9'd91;
            4'd6:    v = 9'd122;
            4'd7:    v = 9'd152;
            4'd8:    v = 9'd183;
            4'd9:    v = 9'd214;
            4'd10:   v = 9'd244;
            4'd11:   v = 9'd275;
            4'd12:   v = 9'd305;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    typedef struct packed
    {
        logic             err;
        logic             eth;
        logic [12:0]      yg;
        logic [6:0]       cest;
        logic [8:0]       tm;
        logic [DAY_W-1:0] day;
        logic [JDN_W-1:0] ejdn;
    } f1_t;

    logic             f_en;
    logic             f1_valid_reg;
    logic             f2_valid_reg;
    f1_t              f1_reg;
    f1_t              f1_next;
    cdn_entry_t       f2_reg;
    cdn_entry_t       f2_next;
    logic             eth;
    logic [MONTH_W-1:0] month_max;
    logic [12:0]      yg;
    logic [19:0]      cest_prod;
    logic [12:0]      rem100;
    logic [8:0]       t_lo;
    logic [8:0]       t_hi;
    logic [8:0]       t_sel;
    logic [23:0]      base_prod;
    logic [JDN_W-1:0] gjdn;

    // Both stages move together; the last one waits on the queue.
    assign f_en     = !f2_valid_reg || q_ready;
    assign in_ready = f_en;
    assign q_valid  = f2_valid_reg;
    assign q_data   = f2_reg;

    // Stage one: range check, Ethiopian day number, century estimate.
    assign eth       = (cal_t'(opcode) == CAL_ETH);
    assign month_max = eth ? ETH_MONTHS : GREG_MONTHS;
    assign yg        = 13'(year_in) + 13'd4800 - ((month_in <= FEBRUARY) ? 13'd1 : 13'd0);
    assign cest_prod = 20'(yg) * 20'd81;

    always_comb
    begin
        f1_next.err  = (year_in < YEAR_MIN) || (year_in > YEAR_MAX) || (month_in == '0)
                       || (month_in > month_max) || (day_in == '0);
        f1_next.eth  = eth;
        f1_next.yg   = yg;
        f1_next.cest = cest_prod[19:13];
        f1_next.tm   = month_term(month_in);
        f1_next.day  = day_in;
        f1_next.ejdn = (22'(year_in) - 22'd1) * 22'd365 + 22'(year_in[11:2])
                       + (22'(month_in) - 22'd1) * 22'd30 + 22'(day_in) + ETH_EPOCH;
    end

    // Stage two: century correction and the Gregorian day number.
    assign rem100    = f1_reg.yg - 13'(f1_reg.cest) * 13'd100;
    assign t_lo      = (9'(f1_reg.cest) + 9'd1) * 9'd3 >> 2;
    assign t_hi      = (9'(f1_reg.cest) + 9'd2) * 9'd3 >> 2;
    assign t_sel     = (rem100 >= 13'd100) ? t_hi : t_lo;
    assign base_prod = 24'(f1_reg.yg) * 24'd1461;
    assign gjdn      = base_prod[23:2] + 22'(f1_reg.tm) + 22'(f1_reg.day) - 22'(t_sel)
                       - GREG_OFFSET;

    always_comb
    begin
        f2_next.err = f1_reg.err;
        f2_next.jdn = f1_reg.eth ? f1_reg.ejdn : gjdn;
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end
        else if (f_en)
        begin
            f1_valid_reg <= in_valid;
            f2_valid_reg <= f1_valid_reg;
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (f_en)
        begin
            f1_reg <= f1_next;
            f2_reg <= f2_next;
        end
    end

endmodule

// ===== hdl/cdn_back.sv =====
// Back pipeline: turns a day number into Gregorian and Ethiopian dates.
`include "assert_macros.svh"

module cdn_back import cdn_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_ready,
    input  cdn_entry_t         q_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [JDN_W-1:0]   day_number,
    output logic [DAY_W-1:0]   greg_day,
    output logic [MONTH_W-1:0] greg_month,
    output logic [YEAR_W-1:0]  greg_year,
    output logic [DAY_W-1:0]   eth_day,
    output logic [MONTH_W-1:0] eth_month,
    output logic [YEAR_W-1:0]  eth_year,
    output logic [1:0]         cycle_day,
    output logic               input_error
);

    localparam int STAGES = 7;

    // Days before month index j in the inverse formula, (2447*j)/80.
    function automatic logic [9:0] day_base(input logic [3:0] j);
        logic [9:0] v;
        unique case (j)
            4'd0:    v = 10'd0;
            4'd1:    v = 10'd30;
            4'd2:    v = 10'd61;
            4'd3:    v = 10'd91;
            4'd4:    v = 10'd122;
            4'd5:    v = 10'd152;
            4'd6:    v = 10'd183;
            4'd7:    v = 10'd214;
            4'd8:    v = 10'd244;
            4'd9:    v = 10'd275;
            4'd10:   v = 10'd305;
            4'd11:   v = 10'd336;
            4'd12:   v = 10'd367;
            4'd13:   v = 10'd397;
            4'd14:   v = 10'd428;
            default: v = 10'd458;
        endcase
        return v;
    endfunction

    typedef struct packed
    {
        logic             err;
        logic [JDN_W-1:0] jdn;
        logic [23:0]      x;
        logic [6:0]       nest;
        logic [20:0]      t;
        logic [10:0]      qest;
    } s1_t;

    typedef struct packed
    {
        logic             err;
        logic [JDN_W-1:0] jdn;
        logic [6:0]       n;
        logic [15:0]      l2;
        logic [10:0]      q;
        logic [10:0]      r;
    } s2_t;

    typedef struct packed
    {
        logic             err;
        logic [JDN_W-1:0] jdn;
        logic [6:0]       n;
        logic [15:0]      l2;
        logic [6:0]       iest;
        logic [11:0]      ey;
        logic [8:0]       doy;
    } s3_t;

    typedef struct packed
    {
        logic             err;
        logic [JDN_W-1:0] jdn;
        logic [6:0]       n;
        logic [15:0]      l2;
        logic [6:0]       i;
        logic [11:0]      ey;
        logic [8:0]       doy;
        logic [3:0]       mo;
    } s4_t;

    typedef struct packed
    {
        logic             err;
        logic [JDN_W-1:0] jdn;
        logic [6:0]       n;
        logic [6:0]       i;
        logic [9:0]       l3;
        logic [11:0]      ey;
        logic [3:0]       em;
        logic [4:0]       ed;
    } s5_t;

    typedef struct packed
    {
        logic             err;
        logic [JDN_W-1:0] jdn;
        logic [6:0]       n;
        logic [6:0]       i;
        logic [9:0]       l3;
        logic [3:0]       j;
        logic [11:0]      ey;
        logic [3:0]       em;
        logic [4:0]       ed;
    } s6_t;

    typedef struct packed
    {
        logic               input_error;
        logic [JDN_W-1:0]   day_number;
        logic [DAY_W-1:0]   greg_day;
        logic [MONTH_W-1:0] greg_month;
        logic [YEAR_W-1:0]  greg_year;
        logic [DAY_W-1:0]   eth_day;
        logic [MONTH_W-1:0] eth_month;
        logic [YEAR_W-1:0]  eth_year;
        logic [1:0]         cycle_day;
    } s7_t;

    logic              b_en;
    logic [STAGES-1:0] valid_reg;
    s1_t               s1_reg;
    s1_t               s1_next;
    s2_t               s2_reg;
    s2_t               s2_next;
    s3_t               s3_reg;
    s3_t               s3_next;
    s4_t               s4_reg;
    s4_t               s4_next;
    s5_t               s5_reg;
    s5_t               s5_next;
    s6_t               s6_reg;
    s6_t               s6_next;
    s7_t               s7_reg;
    s7_t               s7_next;

    // Whole pipeline advances unless a finished result is still waiting.
    assign b_en      = !valid_reg[STAGES-1] || out_ready;
    assign q_ready   = b_en;
    assign out_valid = valid_reg[STAGES-1];

    // Stage one: quotient estimates for the 400-year and 4-year cycles.
    always_comb
    begin
        logic [JDN_W-1:0] l;
        logic [30:0]      pn;
        logic [31:0]      pt;
        l            = q_data.jdn + 22'd68569;
        s1_next.err  = q_data.err;
        s1_next.jdn  = q_data.jdn;
        s1_next.x    = {l, 2'b00};
        pn           = 31'({l, 2'b00}) * 31'd114;
        s1_next.nest = pn[30:24];
        s1_next.t    = 21'(q_data.jdn - 22'd1723856);
        pt           = 32'(s1_next.t) * 32'd1435;
        s1_next.qest = pt[31:21];
    end

    // Stage two: correct both quotients and keep the remainders.
    always_comb
    begin
        logic [23:0] rn;
        logic [23:0] rn_c;
        logic        nhi;
        logic [20:0] rq;
        logic [20:0] rq_c;
        logic        qhi;
        rn          = s1_reg.x - 24'(s1_reg.nest) * 24'd146097;
        nhi         = (rn >= 24'd146097);
        rn_c        = nhi ? (rn - 24'd146097) : rn;
        rq          = s1_reg.t - 21'(s1_reg.qest) * 21'd1461;
        qhi         = (rq >= 21'd1461);
        rq_c        = qhi ? (rq - 21'd1461) : rq;
        s2_next.err = s1_reg.err;
        s2_next.jdn = s1_reg.jdn;
        s2_next.n   = s1_reg.nest + 7'(nhi);
        s2_next.l2  = rn_c[17:2];
        s2_next.q   = s1_reg.qest + 11'(qhi);
        s2_next.r   = rq_c[10:0];
    end

    // Stage three: estimate of the year within the century; Ethiopian year and day of year.
    always_comb
    begin
        logic [16:0] a;
        logic [24:0] pi;
        logic [2:0]  k;
        logic        last_day;
        a  = 17'(s2_reg.l2) + 17'd1;
        pi = 25'(a) * 25'd179;
        last_day = 1'b0;
        if (s2_reg.r >= 11'd1460)
        begin
            k        = 3'd4;
            last_day = 1'b1;
            s3_next.doy = 9'd365;
        end
        else if (s2_reg.r >= 11'd1095)
        begin
            k           = 3'd3;
            s3_next.doy = 9'(s2_reg.r - 11'd1095);
        end
        else if (s2_reg.r >= 11'd730)
        begin
            k           = 3'd2;
            s3_next.doy = 9'(s2_reg.r - 11'd730);
        end
        else if (s2_reg.r >= 11'd365)
        begin
            k           = 3'd1;
            s3_next.doy = 9'(s2_reg.r - 11'd365);
        end
        else
        begin
            k           = 3'd0;
            s3_next.doy = 9'(s2_reg.r);
        end
        s3_next.err  = s2_reg.err;
        s3_next.jdn  = s2_reg.jdn;
        s3_next.n    = s2_reg.n;
        s3_next.l2   = s2_reg.l2;
        s3_next.iest = pi[22:16];
        s3_next.ey   = 12'({s2_reg.q, 2'b00}) + 12'(k) - 12'(last_day);
    end

    // Stage four: correct the year-in-century quotient; Ethiopian month index.
    always_comb
    begin
        logic [16:0] a;
        logic [27:0] ri;
        logic [3:0]  mo;
        a  = 17'(s3_reg.l2) + 17'd1;
        ri = 28'(a) * 28'd4000 - 28'(s3_reg.iest) * 28'd1461001;
        mo = 4'd0;
        for (int k = 1; k <= 12; k++)
        begin
            mo = mo + 4'(s3_reg.doy >= 9'(30 * k));
        end
        s4_next.err = s3_reg.err;
        s4_next.jdn = s3_reg.jdn;
        s4_next.n   = s3_reg.n;
        s4_next.l2  = s3_reg.l2;
        s4_next.i   = s3_reg.iest + 7'(ri >= 28'd1461001);
        s4_next.ey  = s3_reg.ey;
        s4_next.doy = s3_reg.doy;
        s4_next.mo  = mo;
    end

    // Stage five: day within the Gregorian year; Ethiopian month and day.
    always_comb
    begin
        logic [17:0] pl;
        logic [15:0] l3w;
        logic [8:0]  edw;
        pl          = 18'(s4_reg.i) * 18'd1461;
        l3w         = s4_reg.l2 - pl[17:2] + 16'd31;
        edw         = s4_reg.doy - 9'(s4_reg.mo) * 9'd30 + 9'd1;
        s5_next.err = s4_reg.err;
        s5_next.jdn = s4_reg.jdn;
        s5_next.n   = s4_reg.n;
        s5_next.i   = s4_reg.i;
        s5_next.l3  = l3w[9:0];
        s5_next.ey  = s4_reg.ey;
        s5_next.em  = s4_reg.mo + 4'd1;
        s5_next.ed  = edw[4:0];
    end

    // Stage six: Gregorian month index by comparison against month boundaries.
    always_comb
    begin
        logic [16:0] x80;
        logic [3:0]  j;
        x80 = 17'(s5_reg.l3) * 17'd80;
        j   = 4'd0;
        for (int k = 1; k <= 15; k++)
        begin
            j = j + 4'(x80 >= 17'(2447 * k));
        end
        s6_next.err = s5_reg.err;
        s6_next.jdn = s5_reg.jdn;
        s6_next.n   = s5_reg.n;
        s6_next.i   = s5_reg.i;
        s6_next.l3  = s5_reg.l3;
        s6_next.j   = j;
        s6_next.ey  = s5_reg.ey;
        s6_next.em  = s5_reg.em;
        s6_next.ed  = s5_reg.ed;
    end

    // Stage seven: Gregorian date, then zero everything for an out-of-range date.
    always_comb
    begin
        logic [9:0] gdw;
        logic       wrap;
        gdw  = s6_reg.l3 - day_base(s6_reg.j);
        wrap = (s6_reg.j >= 4'd11);
        if (s6_reg.err)
        begin
            s7_next             = '0;
            s7_next.input_error = 1'b1;
        end
        else
        begin
            s7_next.input_error = 1'b0;
            s7_next.day_number  = s6_reg.jdn;
            s7_next.greg_day    = gdw[4:0];
            s7_next.greg_month  = s6_reg.j + 4'd2 - (wrap ? 4'd12 : 4'd0);
            s7_next.greg_year   = 12'd100 * (12'(s6_reg.n) - 12'd49) + 12'(s6_reg.i)
                                  + 12'(wrap);
            s7_next.eth_day     = s6_reg.ed;
            s7_next.eth_month   = s6_reg.em;
            s7_next.eth_year    = s6_reg.ey;
            s7_next.cycle_day   = s6_reg.jdn[1:0];
        end
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (b_en)
        begin
            valid_reg <= {valid_reg[STAGES-2:0], q_valid};
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (b_en)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
            s5_reg <= s5_next;
            s6_reg <= s6_next;
            s7_reg <= s7_next;
        end
    end

    // Result ports come from the last stage register.
    assign day_number  = s7_reg.day_number;
    assign greg_day    = s7_reg.greg_day;
    assign greg_month  = s7_reg.greg_month;
    assign greg_year   = s7_reg.greg_year;
    assign eth_day     = s7_reg.eth_day;
    assign eth_month   = s7_reg.eth_month;
    assign eth_year    = s7_reg.eth_year;
    assign cycle_day   = s7_reg.cycle_day;
    assign input_error = s7_reg.input_error;

    `ASSERT_IMPLY(a_err_zero, out_valid && input_error,
                  day_number == '0 && greg_year == '0 && eth_year == '0,
                  "error result not cleared")
    `ASSERT_IMPLY(a_greg_month, out_valid && !input_error,
                  greg_month >= 4'd1 && greg_month <= 4'd12, "Gregorian month out of range")
    `ASSERT_IMPLY(a_eth_month, out_valid && !input_error,
                  eth_month >= 4'd1 && eth_month <= 4'd13, "Ethiopian month out of range")
    `ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                 out_valid && $stable(day_number), "waiting result changed")

endmodule

// ===== hdl/calendar_day_number_converter_top.sv =====
// Calendar day-number converter: a Gregorian or Ethiopian date in, its Julian day number,
// Gregorian date, Ethiopian date and four-day cycle index out. One date can be taken
// every cycle while in_ready is high. A two-stage front pipeline checks the date and
// forms the day number, a queue of QUEUE_DEPTH entries follows, and a seven-stage back
// pipeline does the inverse conversions with constant-reciprocal divisions. The front
// keeps taking dates while the output is stalled until the queue fills. An out-of-range
// year or month, or a zero day, gives a result with input_error set and every other
// field zero.
module calendar_day_number_converter_top import cdn_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               opcode,
    input  logic [YEAR_W-1:0]  year_in,
    input  logic [MONTH_W-1:0] month_in,
    input  logic [DAY_W-1:0]   day_in,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [JDN_W-1:0]   day_number,
    output logic [DAY_W-1:0]   greg_day,
    output logic [MONTH_W-1:0] greg_month,
    output logic [YEAR_W-1:0]  greg_year,
    output logic [DAY_W-1:0]   eth_day,
    output logic [MONTH_W-1:0] eth_month,
    output logic [YEAR_W-1:0]  eth_year,
    output logic [1:0]         cycle_day,
    output logic               input_error
);

    logic       fq_valid;
    logic       fq_ready;
    cdn_entry_t fq_data;
    logic       qb_valid;
    logic       qb_ready;
    cdn_entry_t qb_data;

    // Date check and day-number formation.
    cdn_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .opcode   (opcode),
        .year_in  (year_in),
        .month_in (month_in),
        .day_in   (day_in),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_data   (fq_data)
    );

    // Queue between the two pipelines.
    cdn_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_data),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_data  (qb_data)
    );

    // Inverse conversions and result register.
    cdn_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (qb_valid),
        .q_ready     (qb_ready),
        .q_data      (qb_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .day_number  (day_number),
        .greg_day    (greg_day),
        .greg_month  (greg_month),
        .greg_year   (greg_year),
        .eth_day     (eth_day),
        .eth_month   (eth_month),
        .eth_year    (eth_year),
        .cycle_day   (cycle_day),
        .input_error (input_error)
    );

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the calendar day-number converter top level.
`timescale 1ns / 100ps

module tb import cdn_pkg::*;;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 6;
    localparam int LONG_HOLD    = 80;
    localparam int DRAIN_CYCLES = 30;
    localparam int IDLE_LIMIT   = 3000;
    localparam int MAX_REPORTS  = 10;

    // One date offered on the input channel.
    typedef struct packed
    {
        cal_t               cal;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } date_item_t;

    // Every field of one converted date.
    typedef struct packed
    {
        logic [JDN_W-1:0]   day_number;
        logic [DAY_W-1:0]   greg_day;
        logic [MONTH_W-1:0] greg_month;
        logic [YEAR_W-1:0]  greg_year;
        logic [DAY_W-1:0]   eth_day;
        logic [MONTH_W-1:0] eth_month;
        logic [YEAR_W-1:0]  eth_year;
        logic [1:0]         cycle_day;
        logic               input_error;
    } conversion_t;

    logic               clk;
    logic               rst_n       = 1'b0;
    logic               in_valid    = 1'b0;
    logic               in_ready;
    logic               opcode      = 1'b0;
    logic [YEAR_W-1:0]  year_in     = '0;
    logic [MONTH_W-1:0] month_in    = '0;
    logic [DAY_W-1:0]   day_in      = '0;
    logic               out_valid;
    logic               out_ready   = 1'b0;
    logic [JDN_W-1:0]   day_number;
    logic [DAY_W-1:0]   greg_day;
    logic [MONTH_W-1:0] greg_month;
    logic [YEAR_W-1:0]  greg_year;
    logic [DAY_W-1:0]   eth_day;
    logic [MONTH_W-1:0] eth_month;
    logic [YEAR_W-1:0]  eth_year;
    logic [1:0]         cycle_day;
    logic               input_error;

    date_item_t  dates_to_send[$];
    conversion_t expected_conversions[$];
    date_item_t  date_on_bus;

    int queued_count  = 0;
    int sent_count    = 0;
    int fail_count    = 0;
    int gap_left      = 0;
    int stall_left    = 0;
    int hold_left     = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    int idle_cycles   = 0;
    bit steady_flow   = 1'b0;

    calendar_day_number_converter_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .year_in     (year_in),
        .month_in    (month_in),
        .day_in      (day_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .day_number  (day_number),
        .greg_day    (greg_day),
        .greg_month  (greg_month),
        .greg_year   (greg_year),
        .eth_day     (eth_day),
        .eth_month   (eth_month),
        .eth_year    (eth_year),
        .cycle_day   (cycle_day),
        .input_error (input_error)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Converts one date to its day number and both calendar forms.
    function automatic conversion_t convert_date(input date_item_t date);
        conversion_t res;
        longint y, m, d, a, jdn, l, n, i, j, gd, gm, gy, t, q, r, doy;
        longint ey, em, ed;
        longint month_max;
        res = '0;
        y = longint'(date.year);
        m = longint'(date.month);
        d = longint'(date.day);
        month_max = (date.cal == CAL_ETH) ? 13 : 12;
        if (y < 1000 || y > 3000 || m < 1 || m > month_max || d < 1)
        begin
            res.input_error = 1'b1;
            return res;
        end
        if (date.cal == CAL_GREG)
        begin
            a = (m <= 2) ? -1 : 0;
            jdn = (1461 * (y + 4800 + a)) / 4 + (367 * (m - 2 - 12 * a)) / 12
                - (3 * ((y + 4900 + a) / 100)) / 4 + d - 32075;
        end
        else
        begin
            jdn = (y - 1) * 365 + y / 4 + (m - 1) * 30 + d + 1724220;
        end
        // Gregorian date from the day number.
        l = jdn + 68569;
        n = (4 * l) / 146097;
        l = l - (146097 * n + 3) / 4;
        i = (4000 * (l + 1)) / 1461001;
        l = l - (1461 * i) / 4 + 31;
        j = (80 * l) / 2447;
        gd = l - (2447 * j) / 80;
        l = j / 11;
        gm = j + 2 - 12 * l;
        gy = 100 * (n - 49) + i + l;
        // Ethiopian date from the four-year cycle.
        t = jdn - 1723856;
        q = t / 1461;
        r = t % 1461;
        doy = r % 365 + 365 * (r / 1460);
        ey = 4 * q + r / 365 - r / 1460;
        em = doy / 30 + 1;
        ed = doy % 30 + 1;
        res.day_number = jdn[JDN_W-1:0];
        res.greg_day   = gd[DAY_W-1:0];
        res.greg_month = gm[MONTH_W-1:0];
        res.greg_year  = gy[YEAR_W-1:0];
        res.eth_year   = ey[YEAR_W-1:0];
        res.eth_month  = em[MONTH_W-1:0];
        res.eth_day    = ed[DAY_W-1:0];
        res.cycle_day  = jdn[1:0];
        return res;
    endfunction

    // Random date: mostly well-formed, some at the year limits, some with every field at full width.
    function automatic date_item_t random_date();
        date_item_t date;
        int pick;
        date.cal = cal_t'(1'($urandom_range(0, 1)));
        pick = $urandom_range(0, 99);
        if (pick < 80)
        begin
            date.year  = YEAR_W'($urandom_range(1000, 3000));
            date.month = MONTH_W'($urandom_range(1, (date.cal == CAL_ETH) ? 13 : 12));
            date.day   = ($urandom_range(0, 3) == 0) ? DAY_W'($urandom_range(1, 31))
                                                      : DAY_W'($urandom_range(1, 28));
        end
        else if (pick < 88)
        begin
            date.year  = ($urandom_range(0, 1) == 0) ? 12'd1000 : 12'd3000;
            date.month = MONTH_W'($urandom_range(1, 13));
            date.day   = DAY_W'($urandom_range(1, 31));
        end
        else
        begin
            date.year  = YEAR_W'($urandom_range(0, 4095));
            date.month = MONTH_W'($urandom_range(0, 15));
            date.day   = DAY_W'($urandom_range(0, 31));
        end
        return date;
    endfunction

    // Idle length: mostly none, some short, a few long.
    function automatic int random_idle();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        else if (pick < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    task automatic queue_date(input cal_t cal, input int y, input int m, input int d);
        date_item_t date;
        date.cal   = cal;
        date.year  = YEAR_W'(y);
        date.month = MONTH_W'(m);
        date.day   = DAY_W'(d);
        dates_to_send.push_back(date);
        queued_count++;
    endtask

    task automatic queue_random(input int count);
        for (int k = 0; k < count; k++)
        begin
            dates_to_send.push_back(random_date());
            queued_count++;
        end
    endtask

    task automatic wait_all_sent();
        while (sent_count != queued_count)
            @(negedge clk);
    endtask

    task automatic wait_all_converted();
        while (sent_count != queued_count || expected_conversions.size() != 0)
            @(negedge clk);
    endtask

    // Input driver: records each transfer, then offers the next date after its gap.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            opcode   <= 1'b0;
            year_in  <= '0;
            month_in <= '0;
            day_in   <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
            begin
                expected_conversions.push_back(convert_date(date_on_bus));
                sent_count++;
            end
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (dates_to_send.size() > 0)
            begin
                date_on_bus = dates_to_send.pop_front();
                opcode   <= date_on_bus.cal;
                year_in  <= date_on_bus.year;
                month_in <= date_on_bus.month;
                day_in   <= date_on_bus.day;
                in_valid <= 1'b1;
                gap_left = steady_flow ? 0 : random_idle();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Output monitor: checks each transfer, then chooses the next ready level.
    always @(posedge clk or negedge rst_n)
    begin
        conversion_t want;
        conversion_t got;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = '{day_number, greg_day, greg_month, greg_year, eth_day,
                        eth_month, eth_year, cycle_day, input_error};
                if (expected_conversions.size() == 0)
                begin
                    if (fail_count < MAX_REPORTS)
                        $display("ERROR: result with no date pending, day_number %0d",
                                 day_number);
                    fail_count++;
                end
                else
                begin
                    want = expected_conversions.pop_front();
                    if (got.day_number !== want.day_number
                        || got.greg_day !== want.greg_day
                        || got.greg_month !== want.greg_month
                        || got.greg_year !== want.greg_year
                        || got.eth_day !== want.eth_day
                        || got.eth_month !== want.eth_month
                        || got.eth_year !== want.eth_year
                        || got.cycle_day !== want.cycle_day
                        || got.input_error !== want.input_error)
                    begin
                        if (fail_count < MAX_REPORTS)
                        begin
                            $display("ERROR: expected jdn %0d g %0d/%0d/%0d e %0d/%0d/%0d c %0d err %0d",
                                     want.day_number, want.greg_year, want.greg_month,
                                     want.greg_day, want.eth_year, want.eth_month,
                                     want.eth_day, want.cycle_day, want.input_error);
                            $display("       actual   jdn %0d g %0d/%0d/%0d e %0d/%0d/%0d c %0d err %0d",
                                     got.day_number, got.greg_year, got.greg_month,
                                     got.greg_day, got.eth_year, got.eth_month,
                                     got.eth_day, got.cycle_day, got.input_error);
                        end
                        fail_count++;
                    end
                end
            end
            // A requested long hold takes priority over random stalls.
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (holds_served != hold_requests)
            begin
                holds_served++;
                hold_left = LONG_HOLD - 1;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                stall_left = steady_flow ? 0 : random_idle();
                out_ready <= (stall_left == 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    // Watchdog on cycles with no transfer on either channel.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("calendar_day_number_converter_top verification failed");
                $finish;
            end
        end
    end

    // Test sequence.
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed dates: range limits, leap days, month-end carry and every error.
        queue_date(CAL_GREG, 1000, 1, 1);
        queue_date(CAL_GREG, 3000, 12, 31);
        queue_date(CAL_ETH, 1000, 1, 1);
        queue_date(CAL_ETH, 3000, 13, 31);
        queue_date(CAL_ETH, 3000, 13, 6);
        queue_date(CAL_GREG, 2000, 2, 29);
        queue_date(CAL_GREG, 1900, 2, 29);
        queue_date(CAL_GREG, 2023, 2, 31);
        queue_date(CAL_GREG, 2024, 12, 31);
        queue_date(CAL_ETH, 2015, 13, 6);
        queue_date(CAL_ETH, 2016, 13, 5);
        queue_date(CAL_ETH, 1999, 13, 31);
        queue_date(CAL_GREG, 1582, 10, 15);
        queue_date(CAL_ETH, 2012, 1, 1);
        queue_date(CAL_GREG, 999, 6, 15);
        queue_date(CAL_ETH, 3001, 1, 1);
        queue_date(CAL_GREG, 0, 0, 0);
        queue_date(CAL_ETH, 4095, 15, 31);
        queue_date(CAL_GREG, 2000, 13, 1);
        queue_date(CAL_ETH, 2000, 14, 1);
        queue_date(CAL_GREG, 2000, 15, 31);
        queue_date(CAL_GREG, 2000, 0, 10);
        queue_date(CAL_ETH, 2000, 5, 0);
        queue_date(CAL_GREG, 4095, 12, 0);

        // The sender pauses here until every conversion has come back.
        wait_all_converted();

        // Long receiver hold while dates keep coming back to back.
        steady_flow = 1'b1;
        hold_requests++;
        for (int k = 0; k < 40; k++)
        begin
            dates_to_send.push_back(random_date());
            queued_count++;
        end
        wait_all_sent();
        steady_flow = 1'b0;

        queue_random(180);
        wait_all_converted();

        steady_flow = 1'b1;
        queue_random(80);
        wait_all_sent();
        steady_flow = 1'b0;
        queue_random(110);

        wait_all_converted();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("calendar_day_number_converter_top verification clean");
        else
            $display("calendar_day_number_converter_top verification failed");
        $finish;
    end

endmodule
